// ----- hdl/msd_pkg.sv -----
// Shared types and constants of the multi-tap sinc crossfade delay.
package msd_pkg;

  // pi and 1/pi in Q30
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [31:0] INV_PI_Q30 = 32'd341782638;

  // tap weight: signed Q20 in this many bits
  localparam int W_BITS = 22;
  localparam logic signed [W_BITS-1:0] W_ONE = 22'sh100000;

  // signed width of a raw read position before wrapping
  localparam int POS_W = 28;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TAP_PAIRS    = 2'd0;
  localparam logic [1:0] REG_FIRST_DELAY  = 2'd1;
  localparam logic [1:0] REG_SECOND_DELAY = 2'd2;

  typedef struct packed {
    logic [2:0]  tap_pairs;
    logic [19:0] first_delay;
    logic [19:0] second_delay;
  } msd_cfg_t;

  // back end to front end
  typedef struct packed {
    logic pop;
    logic store_ready;
  } msd_ctl_t;

endpackage

// ----- hdl/multitap_sinc_crossfade_delay_top.sv -----
// Top level: configuration registers, front end, back end.
//
//  channel   direction  handshake          payload
//  config    in/out     psel/penable       paddr, pwdata, prdata (APB style)
//  input     in         in_valid/in_ready  sample_in, blend
//  output    out        out_valid/out_ready sample_out
//
// After reset the delay store is swept to zero, one entry a cycle; in_ready
// stays low during the sweep. DELAY_DEPTH is a power of two, so read
// positions wrap by masking.
// A request with equal delays goes from its pop through the position and read
// steps to the result register. With different delays it walks 2K + 2 taps,
// and the bit-serial divider, DIVW = SINC_TABLE_BITS + 36 bits wide, forms
// each tap weight; a tap whose weight is an exact one or zero skips the
// divider.
// A two-entry queue takes requests while the back end works; a finished
// result waits in the output register, and the next request stalls only in
// its finish step while that register is still full.
module multitap_sinc_crossfade_delay_top #(
  parameter int DELAY_DEPTH     = 4096,
  parameter int MAX_TAP_PAIRS   = 7,
  parameter int SAMPLE_BITS     = 24,
  parameter int SINC_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [16:0]                   blend,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);
  import msd_pkg::*;

  msd_cfg_t                      cfg;
  msd_ctl_t                      ctl;
  logic                          q_valid;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic [SINC_TABLE_BITS:0]      q_alpha;
  logic                          wr_en;

  // register write on the access phase; no wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_pairs    <= 3'd1;
      cfg.first_delay  <= 20'd256;
      cfg.second_delay <= 20'd512;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TAP_PAIRS:    cfg.tap_pairs    <= pwdata[2:0];
        REG_FIRST_DELAY:  cfg.first_delay  <= pwdata[19:0];
        REG_SECOND_DELAY: cfg.second_delay <= pwdata[19:0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TAP_PAIRS:    prdata = 32'(cfg.tap_pairs);
      REG_FIRST_DELAY:  prdata = 32'(cfg.first_delay);
      REG_SECOND_DELAY: prdata = 32'(cfg.second_delay);
      default:          prdata = '0;
    endcase
  end

  // front end: accept requests, quantize blend, queue them
  msd_front #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINC_TABLE_BITS (SINC_TABLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .blend     (blend),
    .ctl       (ctl),
    .q_valid   (q_valid),
    .q_sample  (q_sample),
    .q_alpha   (q_alpha)
  );

  // back end: store the sample, walk the taps, weight and sum them
  msd_back #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .MAX_TAP_PAIRS   (MAX_TAP_PAIRS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINC_TABLE_BITS (SINC_TABLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_sample   (q_sample),
    .q_alpha    (q_alpha),
    .ctl        (ctl),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );
endmodule

// ----- hdl/msd_div.sv -----
// Bit-serial restoring divider: unsigned quotient, one bit per cycle.
module msd_div #(
  parameter int DIVW = 46,
  parameter int DVW  = 21
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DIVW-1:0] dividend,
  input  logic [DVW-1:0]  divisor,
  output logic            done,
  output logic [DIVW-1:0] quo
);
  localparam int CW = $clog2(DIVW + 1);

  logic [DVW-1:0] rem;
  logic [DVW-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic [DVW:0]   sh;
  logic [DVW:0]   diff;

  assign sh   = {rem, quo[DIVW-1]};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CW'(DIVW);
      end else if (cnt != '0) begin
        if (!diff[DVW]) begin
          rem <= diff[DVW-1:0];
          quo <= {quo[DIVW-2:0], 1'b1};
        end else begin
          rem <= sh[DVW-1:0];
          quo <= {quo[DIVW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- hdl/msd_front.sv -----
// Front end: takes requests, quantizes blend, holds them in a two-entry queue.
module msd_front #(
  parameter int SAMPLE_BITS     = 24,
  parameter int SINC_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [16:0]                   blend,
  input  msd_pkg::msd_ctl_t             ctl,
  output logic                          q_valid,
  output logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic [SINC_TABLE_BITS:0]      q_alpha
);
  import msd_pkg::*;

  localparam int TB = SINC_TABLE_BITS;

  logic signed [SAMPLE_BITS-1:0] qs [2];
  logic [TB:0]                   qa [2];
  logic                          wptr;
  logic                          rptr;
  logic [1:0]                    cnt;
  logic                          push;
  logic [16:0]                   alpha;
  logic [TB+17:0]                scaled;

  // clamp to one, then round half up to the table grid
  assign alpha  = (blend > 17'd65536) ? 17'd65536 : blend;
  assign scaled = {1'b0, alpha, {TB{1'b0}}} + (TB+18)'(32768);

  assign in_ready = ctl.store_ready && (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_sample = qs[rptr];
  assign q_alpha  = qa[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qs[wptr] <= sample_in;
      qa[wptr] <= scaled[TB+16:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (ctl.pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, ctl.pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end
endmodule

// ----- hdl/msd_back.sv -----
// Back end: delay store, tap sequencer, sinc weight unit and tap accumulator.
module msd_back #(
  parameter int DELAY_DEPTH     = 4096,
  parameter int MAX_TAP_PAIRS   = 7,
  parameter int SAMPLE_BITS     = 24,
  parameter int SINC_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msd_pkg::msd_cfg_t             cfg,
  input  logic                          q_valid,
  input  logic signed [SAMPLE_BITS-1:0] q_sample,
  input  logic [SINC_TABLE_BITS:0]      q_alpha,
  output msd_pkg::msd_ctl_t             ctl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);
  import msd_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int TB   = SINC_TABLE_BITS;
  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int SPW  = AW + 9;
  localparam int TW   = $clog2(2 * MAX_TAP_PAIRS + 3);
  localparam int KW   = $clog2(MAX_TAP_PAIRS + 2);
  localparam int DW   = TW + TB + 3;
  localparam int DIVW = 36 + TB;
  localparam int DVW  = DW;
  localparam int LW   = SB + 10;
  localparam int PW   = LW + W_BITS;
  localparam int ACW  = PW + 6;
  localparam int VW   = ACW - 28;

  localparam logic [SPW-1:0] SPAN   = SPW'(DELAY_DEPTH * 256);
  localparam logic [AW-1:0]  LAST   = AW'(DELAY_DEPTH - 1);
  localparam logic [TB:0]    FULL_A = (TB+1)'(2 ** TB);
  localparam logic [TB:0]    HALF_A = (TB+1)'(2 ** (TB - 1));
  localparam logic signed [VW-1:0] SAT_HI = VW'({1'b0, {(SB-1){1'b1}}});
  localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;

  // series divisors (2n)(2n+1) = 2^e * odd; reciprocals of the odd part,
  // exact for any dividend below 2^31
  localparam logic [31:0] RCP_3   = 32'(((64'd1 << 33) / 64'd3) + 64'd1);
  localparam logic [31:0] RCP_5   = 32'(((64'd1 << 34) / 64'd5) + 64'd1);
  localparam logic [31:0] RCP_21  = 32'(((64'd1 << 36) / 64'd21) + 64'd1);
  localparam logic [31:0] RCP_9   = 32'(((64'd1 << 35) / 64'd9) + 64'd1);
  localparam logic [31:0] RCP_55  = 32'(((64'd1 << 37) / 64'd55) + 64'd1);
  localparam logic [31:0] RCP_39  = 32'(((64'd1 << 37) / 64'd39) + 64'd1);
  localparam logic [31:0] RCP_105 = 32'(((64'd1 << 38) / 64'd105) + 64'd1);

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_POS   = 17'h00004,
    S_TH    = 17'h00008,
    S_T2    = 17'h00010,
    S_TM    = 17'h00020,
    S_TD    = 17'h00040,
    S_TDW   = 17'h00080,
    S_NUM   = 17'h00100,
    S_RA    = 17'h00200,
    S_RB    = 17'h00400,
    S_RC    = 17'h00800,
    S_WT    = 17'h01000,
    S_WTW   = 17'h02000,
    S_MAC   = 17'h04000,
    S_ACC   = 17'h08000,
    S_FIN   = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [SB-1:0] mem [DELAY_DEPTH];
  logic signed [SB-1:0] rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [SB-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;

  logic [AW-1:0]  clr_addr;
  logic [AW-1:0]  wp;
  logic [TB:0]    cur_a;
  logic           mode_tap;
  logic [KW-1:0]  kk_r;
  logic [KW-1:0]  kk;
  logic [SPW-1:0] r;
  logic [SPW-1:0] dm;
  logic [31:0]    th;
  logic [31:0]    t2;
  logic [31:0]    term;
  logic [31:0]    p;
  logic signed [34:0] s;
  logic [2:0]     n;
  logic [33:0]    num;
  logic [TW-1:0]  k;
  logic signed [LW-1:0]     p0;
  logic signed [LW-1:0]     lin;
  logic signed [W_BITS-1:0] w;
  logic signed [PW-1:0]     prod;
  logic signed [ACW-1:0]    acc;

  logic signed [20:0]      delta;
  logic signed [POS_W-1:0] kd;
  logic signed [POS_W-1:0] xpos;
  logic signed [POS_W-1:0] ndelta;

  logic            div_start;
  logic [DIVW-1:0] div_dividend;
  logic [DVW-1:0]  div_divisor;
  logic            div_done;
  logic [DIVW-1:0] div_quo;

  logic [TB:0]       h;
  logic [TB+32:0]    thp;
  logic [63:0]       t2p;
  logic [63:0]       pp;
  logic [33:0]       sp;
  logic [63:0]       np;

  logic [1:0]        q_sh;
  logic [31:0]       q_rcp;
  logic [5:0]        q_post;
  logic [30:0]       qx;
  logic [62:0]       qprod;
  logic [31:0]       qt;

  logic [7:0]        f;
  logic [AW-1:0]     i0;
  logic [AW-1:0]     i1;
  logic [SPW:0]      rs;

  logic signed [TW+1:0]   m;
  logic signed [DW-1:0]   d;
  logic [DW-1:0]          ad;
  logic                   w_special;
  logic signed [W_BITS-1:0] w_fixed;
  logic                   w_neg;
  logic [DIVW-1:0]        wq;
  logic [W_BITS-1:0]      wmag;
  logic                   taps_last;

  logic signed [ACW-1:0] ra;
  logic signed [LW-1:0]  sa;
  logic signed [VW-1:0]  vr;
  logic signed [VW-1:0]  vsat;
  logic                  fin_go;

  msd_div #(.DIVW(DIVW), .DVW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo)
  );

  // ---- configuration-derived values
  assign delta = $signed({1'b0, cfg.second_delay}) - $signed({1'b0, cfg.first_delay});
  assign kk    = (32'(cfg.tap_pairs) > MAX_TAP_PAIRS) ? KW'(MAX_TAP_PAIRS)
                                                      : KW'(cfg.tap_pairs);
  assign kd    = POS_W'($signed({1'b0, kk_r}) * delta);
  assign xpos  = $signed(POS_W'({wp, 8'b0})) - $signed(POS_W'(cfg.first_delay))
               + (mode_tap ? kd : '0);
  assign ndelta = -POS_W'(delta);

  // ---- sine series datapath
  assign h   = (cur_a <= HALF_A) ? cur_a : FULL_A - cur_a;
  assign thp = (TB+33)'(h) * (TB+33)'(PI_Q30);
  assign t2p = 64'(th) * 64'(th);
  assign pp  = 64'(term) * 64'(t2);
  assign sp  = s[34] ? 34'd0 : s[33:0];
  assign np  = 64'(sp) * 64'(INV_PI_Q30);

  // series divide: shift out the power of two, multiply by the reciprocal
  always_comb begin
    unique case (n)
      3'd1: begin q_sh = 2'd1; q_rcp = RCP_3;  q_post = 6'd33; end
      3'd2: begin q_sh = 2'd2; q_rcp = RCP_5;  q_post = 6'd34; end
      3'd3: begin q_sh = 2'd1; q_rcp = RCP_21; q_post = 6'd36; end
      3'd4: begin q_sh = 2'd3; q_rcp = RCP_9;  q_post = 6'd35; end
      3'd5: begin q_sh = 2'd1; q_rcp = RCP_55; q_post = 6'd37; end
      3'd6: begin q_sh = 2'd2; q_rcp = RCP_39; q_post = 6'd37; end
      default: begin
        q_sh = 2'd1; q_rcp = RCP_105; q_post = 6'd38;
      end
    endcase
  end

  assign qx = 31'(p >> q_sh);
  assign qt = 32'(qprod >> q_post);

  // ---- read position
  assign f  = r[7:0];
  assign i0 = r[AW+7:8];
  assign i1 = (i0 == LAST) ? '0 : i0 + AW'(1);
  assign rs = {1'b0, r} + {1'b0, dm};

  // ---- tap weight
  assign m  = $signed((TW+2)'(k) - (TW+2)'(kk_r));
  assign d  = (DW'(m) <<< TB) - $signed(DW'(cur_a));
  assign ad = d[DW-1] ? DW'(-d) : DW'(d);
  assign w_special = (cur_a == '0) || (cur_a == FULL_A);
  assign w_fixed   = (((m == '0) && (cur_a == '0)) || ((m == (TW+2)'(1)) && (cur_a == FULL_A)))
                   ? W_ONE : '0;
  assign w_neg     = m[0] ? (d < 0) : (d > 0);
  assign wq        = div_quo + DIVW'(512);
  assign wmag      = wq[W_BITS+9:10];
  assign taps_last = (k == (TW'({kk_r, 1'b0}) + TW'(1)));

  // ---- rounding and saturation
  assign ra = acc + ACW'(2 ** 27);
  assign sa = lin + LW'(128);
  assign vr = mode_tap ? VW'(ra >>> 28) : VW'(sa >>> 8);
  always_comb begin
    priority if (vr > SAT_HI) begin
      vsat = SAT_HI;
    end else if (vr < SAT_LO) begin
      vsat = SAT_LO;
    end else begin
      vsat = vr;
    end
  end

  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);

  // ---- handshakes with the front end
  assign ctl.store_ready = (state != S_CLEAR);
  assign ctl.pop         = (state == S_IDLE) && q_valid;

  // ---- delay store
  assign mem_we    = (state == S_CLEAR) || ctl.pop;
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : wp;
  assign mem_wdata = (state == S_CLEAR) ? '0 : q_sample;
  assign mem_raddr = (state == S_RA) ? i0 : i1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // ---- divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_WT: begin
        div_start    = !w_special;
        div_dividend = DIVW'({num, {TB{1'b0}}});
        div_divisor  = DVW'(ad);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // ---- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == LAST) state_next = S_IDLE;
      S_IDLE:  if (q_valid) state_next = S_POS;
      S_POS:   state_next = mode_tap ? S_TH : S_RA;
      S_TH:    state_next = S_T2;
      S_T2:    state_next = S_TM;
      S_TM:    state_next = S_TD;
      S_TD:    state_next = S_TDW;
      S_TDW:   state_next = (n == 3'd7) ? S_NUM : S_TM;
      S_NUM:   state_next = S_RA;
      S_RA:    state_next = S_RB;
      S_RB:    state_next = S_RC;
      S_RC:    state_next = mode_tap ? S_WT : S_FIN;
      S_WT:    state_next = w_special ? S_MAC : S_WTW;
      S_WTW:   if (div_done) state_next = S_MAC;
      S_MAC:   state_next = S_ACC;
      S_ACC:   state_next = taps_last ? S_FIN : S_RA;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (fin_go) begin
        wp        <= (wp == LAST) ? '0 : wp + AW'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur_a    <= q_alpha;
        mode_tap <= (delta != '0);
        kk_r     <= kk;
      end
      // wrap by masking: the span is a power of two
      S_POS: begin
        r  <= {1'b0, xpos[AW+7:0]};
        dm <= {1'b0, ndelta[AW+7:0]};
      end
      S_TH:   th <= thp[TB+31:TB];
      S_T2: begin
        t2   <= t2p[61:30];
        term <= th;
        s    <= $signed(35'(th));
        n    <= 3'd1;
      end
      S_TM:   p <= pp[61:30];
      S_TD:   qprod <= 63'(qx) * 63'(q_rcp);
      S_TDW: begin
        term <= qt;
        s    <= n[0] ? s - $signed(35'(qt)) : s + $signed(35'(qt));
        n    <= n + 3'd1;
      end
      S_NUM: begin
        num <= np[63:30];
        k   <= '0;
        acc <= '0;
      end
      S_RB:   p0  <= LW'(rdata * $signed({1'b0, 9'(9'd256 - {1'b0, f})}));
      S_RC:   lin <= p0 + LW'(rdata * $signed({2'b0, f}));
      S_WT:   if (w_special) w <= w_fixed;
      S_WTW:  if (div_done) w <= w_neg ? -$signed(wmag) : $signed(wmag);
      S_MAC:  prod <= lin * w;
      S_ACC: begin
        acc <= acc + ACW'(prod);
        r   <= (rs >= {1'b0, SPAN}) ? SPW'(rs - {1'b0, SPAN}) : rs[SPW-1:0];
        k   <= k + TW'(1);
      end
      S_FIN:  if (fin_go) sample_out <= vsat[SB-1:0];
      default: begin
      end
    endcase
  end

  // ---- checks
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WTW))
    else $error("divider finished with no state waiting for it");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (state == S_IDLE && q_valid && ctl.store_ready))
    else $error("queue popped outside idle");

  a_wp_moves_on_finish: assert property (@(posedge clk) disable iff (rst)
    !fin_go |=> $stable(wp))
    else $error("write pointer moved without a finished request");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside the finish step");
endmodule

// ----- verif/multitap_sinc_crossfade_delay_top_tb.sv -----
// Self-checking testbench for the multi-tap sinc crossfade delay top level.
`timescale 1ns / 100ps

module multitap_sinc_crossfade_delay_top_tb;
  import msd_pkg::*;

  localparam int DEPTH     = 4096;
  localparam int TABLE_B   = 10;
  localparam int FULL_A    = 1 << TABLE_B;
  localparam int SBITS     = 24;
  localparam logic [1:0] REG_UNUSED = 2'd3;  // no register behind this index
  localparam int LONG_HOLD = 3000;           // cycles of receiver hold-off
  localparam int DRAIN_WAIT = 1500;          // longer than the slowest request

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [SBITS-1:0] sample_in, sample_out;
  logic [16:0] blend;

  // Shadow state of the block: delay store, write pointer and registers.
  logic signed [SBITS-1:0] echo_store [DEPTH];
  int unsigned echo_wp;
  int unsigned cfg_pairs, cfg_first, cfg_second;

  logic signed [SBITS-1:0] pending_out[$];
  int unsigned mismatches, results_seen, requests_sent;
  bit idle_en;
  int hold_req, hold_seen, hold_left, stall_left;

  multitap_sinc_crossfade_delay_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_in(sample_in), .blend(blend),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: covers the store sweep, long taps and every stall several times.
  initial begin
    #(64'd20 * 64'd4_000_000);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Linear read at a Q.8 position, result scaled by 256; the position wraps.
  function automatic longint interp_read(longint pos);
    longint span, r, f;
    int unsigned i0, i1;
    span = longint'(DEPTH) * 256;
    r = pos % span;
    if (r < 0) r += span;
    i0 = int'(r >> 8) % DEPTH;
    i1 = (i0 + 1) % DEPTH;
    f  = r & 255;
    return longint'(echo_store[i0]) * (256 - f) + longint'(echo_store[i1]) * f;
  endfunction

  // Signed Q20 weight of sinc(m - a / 2^TABLE_B), sine from a Q30 series.
  function automatic longint sinc_weight(int m, int unsigned a);
    longint unsigned th, t2, term, num, ad, w;
    longint s, d;
    int unsigned h;
    bit neg;
    if ((m == 0 && a == 0) || (m == 1 && a == FULL_A)) return longint'(1) << 20;
    if (a == 0 || a == FULL_A) return 0;
    h  = (a <= FULL_A / 2) ? a : FULL_A - a;
    th = (64'(h) * 64'(PI_Q30)) >> TABLE_B;
    t2 = (th * th) >> 30;
    term = th;
    s = longint'(th);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    num = (64'(s) * 64'(INV_PI_Q30)) >> 30;
    d  = longint'(m) * FULL_A - longint'(a);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    w  = (((num << TABLE_B) / ad) + 64'd512) >> 10;
    neg = (m % 2 != 0) ? (d < 0) : (d > 0);
    return neg ? -longint'(w) : longint'(w);
  endfunction

  // Round half up after a right shift; arithmetic shift gives the floor.
  function automatic longint round_down_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [SBITS-1:0] clamp_sample(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[SBITS-1:0];
  endfunction

  // Store one sample and work out the crossfaded output it produces.
  function automatic logic signed [SBITS-1:0] crossfade_predict(
      logic signed [SBITS-1:0] smp, logic [16:0] bl);
    longint alpha, t1, delta, base, acc, tk;
    int unsigned a;
    int kk;
    logic signed [SBITS-1:0] res;
    echo_store[echo_wp] = smp;
    alpha = (bl > 17'd65536) ? 65536 : longint'(bl);
    a = int'(((alpha << TABLE_B) + 32768) >> 16);
    t1 = cfg_first;
    delta = longint'(cfg_second) - t1;
    base = longint'(echo_wp) * 256;
    if (delta == 0) begin
      res = clamp_sample(round_down_shift(interp_read(base - t1), 8));
    end else begin
      kk = (cfg_pairs > 7) ? 7 : cfg_pairs;
      acc = 0;
      for (int k = 0; k < 2 * kk + 2; k++) begin
        tk = t1 + longint'(k - kk) * delta;
        acc += interp_read(base - tk) * sinc_weight(k - kk, a);
      end
      res = clamp_sample(round_down_shift(acc, 28));
    end
    echo_wp = (echo_wp + 1) % DEPTH;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);  // start a stall burst of random length
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sample at the falling edge; the handshake completes at the next rising one.
  always @(negedge clk) begin
    logic signed [SBITS-1:0] want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", sample_out);
      end else begin
        want = pending_out.pop_front();
        if (sample_out !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample_out mismatch: expected %0d, got %0d", want, sample_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------

  // Offer one request, optionally after an idle burst; leave valid high.
  task automatic send_request(logic signed [SBITS-1:0] smp, logic [16:0] bl);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= smp;
    blend     <= bl;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    pending_out.push_back(crossfade_predict(smp, bl));
    requests_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TAP_PAIRS:    cfg_pairs  = val[2:0];
      REG_FIRST_DELAY:  cfg_first  = val[19:0];
      REG_SECOND_DELAY: cfg_second = val[19:0];
      default: ;
    endcase
  endtask

  task automatic set_delays(int unsigned k, int unsigned t1, int unsigned t2);
    drain_results();
    reg_write(REG_TAP_PAIRS, k);
    reg_write(REG_FIRST_DELAY, t1);
    reg_write(REG_SECOND_DELAY, t2);
  endtask

  function automatic logic [16:0] pick_blend();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 17'($urandom_range(0, 131071));
    if (r == 1) return ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0;
    return 17'($urandom_range(0, 65536));
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset registers, sample and blend extremes, blend above one.
  task automatic test_field_extremes();
    send_request(24'sh7FFFFF, 17'd0);
    send_request(24'sh800000, 17'd65536);
    send_request(24'sh7FFFFF, 17'd131071);
    send_request(24'sh800000, 17'd32768);
    send_request(24'sh000001, 17'd1);
    send_request(24'shFFFFFF, 17'd65535);
    send_request(24'sh000000, 17'd65600);
    send_request(24'sh555555, 17'd16384);
  endtask

  // Equal delays: zero delay, longest delay the store holds, ignored register index.
  task automatic test_single_read();
    set_delays(0, 0, 0);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_request(24'sh123456, 17'd0);
    send_request(24'shABCDEF, 17'd65536);
    send_request(24'sh7FFFFF, 17'd40000);
    set_delays(3, 20'hFFFFF, 20'hFFFFF);
    send_request(24'sh400000, 17'd100);
    send_request(24'shC00000, 17'd60000);
    set_delays(5, 3 * 256 + 128, 3 * 256 + 128);
    send_request(24'sh0F0F0F, 17'd500);
  endtask

  // Tap count extremes, reversed delays, taps that wrap around the store.
  task automatic test_tap_extremes();
    set_delays(7, 10 * 256 + 77, 12 * 256 + 3);
    repeat (4) send_request(24'($urandom), pick_blend());
    set_delays(0, 300, 100);
    repeat (3) send_request(24'($urandom), pick_blend());
    set_delays(2, 0, 20'hFFFFF);
    send_request(24'sh7FFFFF, 17'd65536);
    send_request(24'sh800000, 17'd512);
  endtask

  // Hold the output off so the queue fills, then pause until all is back.
  task automatic test_backpressure();
    set_delays(1, 64 * 256, 64 * 256);
    hold_req++;
    repeat (12) send_request(24'($urandom), pick_blend());
    drain_results();
    repeat (5) send_request(24'($urandom), pick_blend());
  endtask

  // Random settings per phase, mostly musical delays with small tap counts.
  task automatic test_random_phases(int phases, int per_phase);
    int unsigned k, t1, t2;
    int r, spread;
    for (int p = 0; p < phases; p++) begin
      r = $urandom_range(0, 9);
      k = (r < 4) ? 0 : (r < 7) ? 1 : (r < 9) ? $urandom_range(2, 6) : 7;
      t1 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20'hFFFFF)
                                       : $urandom_range(0, 300 * 256);
      r = $urandom_range(0, 11);
      if (r < 2) begin
        t2 = t1;
      end else if (r < 4) begin
        t2 = $urandom_range(0, 20'hFFFFF);
      end else begin
        spread = int'($urandom_range(0, 8 * 256)) - 4 * 256;
        t2 = (int'(t1) + spread < 0) ? 0 : t1 + spread;
        if (t2 > 20'hFFFFF) t2 = 20'hFFFFF;
      end
      set_delays(k, t1, t2);
      repeat (per_phase) send_request(24'($urandom), pick_blend());
    end
  endtask

  // Full rate on both sides.
  task automatic test_no_idle();
    idle_en = 1'b0;
    set_delays(0, 5 * 256 + 9, 2 * 256 + 200);
    repeat (20) send_request(24'($urandom), pick_blend());
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; sample_in = '0; blend = '0;
    idle_en = 1'b1;
    hold_req = 0; hold_seen = 0; hold_left = 0; stall_left = 0;
    mismatches = 0; results_seen = 0; requests_sent = 0;
    foreach (echo_store[i]) echo_store[i] = '0;
    echo_wp = 0;
    cfg_pairs = 1; cfg_first = 256; cfg_second = 512;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_single_read();
    test_tap_extremes();
    test_backpressure();
    test_random_phases(8, 55);
    test_no_idle();

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d requests, %0d results: single read, 2..16 taps,",
             requests_sent, results_seen);
    $display("wrapped and reversed delays, blend clamp, stalls and a full queue");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
